FILE: hdl/threshold_rule_output_timer_top_defines.svh
// Assertion macros for the threshold rule output timer.
// Included by the top level; no other dependencies.
`ifndef THRESHOLD_RULE_OUTPUT_TIMER_TOP_DEFINES_SVH
`define THRESHOLD_RULE_OUTPUT_TIMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TROT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TROT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TROT_ASSERT(label, prop, msg)
`define TROT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: hdl/trot_pkg.sv
// Shared types and constants for the threshold rule output timer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package trot_pkg;

  localparam int unsigned HOLD_MS_W = 31;
  localparam logic [31:0] MS_PER_SECOND = 32'd1000;
  localparam logic [20:0] HOLD_SECONDS_MAX = 21'd2000000;

  localparam logic [2:0] REG_RULE_ENABLED = 3'd0;
  localparam logic [2:0] REG_COMPARE_OPERATOR = 3'd1;
  localparam logic [2:0] REG_RHS_FROM_INPUT = 3'd2;
  localparam logic [2:0] REG_THRESHOLD_VALUE = 3'd3;
  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd4;
  localparam logic [2:0] REG_RULE_MODE = 3'd5;
  localparam logic [2:0] REG_HOLD_SECONDS = 3'd6;

  localparam logic [2:0] OP_GT = 3'd0;
  localparam logic [2:0] OP_GE = 3'd1;
  localparam logic [2:0] OP_LT = 3'd2;
  localparam logic [2:0] OP_LE = 3'd3;
  localparam logic [2:0] OP_EQ = 3'd4;
  localparam logic [2:0] OP_NE = 3'd5;

  localparam logic [1:0] MODE_FOLLOW = 2'd0;

  localparam logic [1:0] CAUSE_FOLLOW = 2'd0;
  localparam logic [1:0] CAUSE_TRIGGER = 2'd1;
  localparam logic [1:0] CAUSE_EXPIRE = 2'd2;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [31:0] measured_value;
    logic signed [31:0] second_value;
  } sample_t;

  typedef struct packed {
    logic       drive_level;
    logic [1:0] drive_cause;
  } drive_t;

  typedef struct packed {
    logic                 rule_enabled;
    logic [2:0]           compare_operator;
    logic                 rhs_from_input;
    logic signed [31:0]   threshold_value;
    logic                 active_level;
    logic [1:0]           rule_mode;
    logic [HOLD_MS_W-1:0] hold_ms;
  } rule_cfg_t;

  typedef struct packed {
    logic        previous_condition;
    logic        hold_active;
    logic [31:0] deadline_ms;
  } rule_state_t;

endpackage

FILE: hdl/trot_cfg.sv
// Configuration register file of the rule; converts the hold time to milliseconds.
// Depends on trot_pkg.
`timescale 1ns / 1ps

module trot_cfg
  import trot_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output rule_cfg_t   cfg
);

  rule_cfg_t            cfg_next;
  logic [20:0]          secs;
  logic [20:0]          secs_sat;
  logic [31:0]          hold_product;

  always_comb begin
    secs = wr_data[20:0];
    if (secs > HOLD_SECONDS_MAX) begin
      secs_sat = HOLD_SECONDS_MAX;
    end else if (secs == 21'd0) begin
      secs_sat = 21'd1;
    end else begin
      secs_sat = secs;
    end
    hold_product = {11'd0, secs_sat} * MS_PER_SECOND;

    cfg_next = cfg;
    if (wr_en) begin
      case (wr_index)
        REG_RULE_ENABLED:     cfg_next.rule_enabled = wr_data[0];
        REG_COMPARE_OPERATOR: cfg_next.compare_operator = wr_data[2:0];
        REG_RHS_FROM_INPUT:   cfg_next.rhs_from_input = wr_data[0];
        REG_THRESHOLD_VALUE:  cfg_next.threshold_value = wr_data;
        REG_ACTIVE_LEVEL:     cfg_next.active_level = wr_data[0];
        REG_RULE_MODE:        cfg_next.rule_mode = wr_data[1:0];
        REG_HOLD_SECONDS:     cfg_next.hold_ms = hold_product[HOLD_MS_W-1:0];
        default:              cfg_next = cfg;
      endcase
    end
  end

  // A zero hold time reads as one second, so the reset value is 1000 ms.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rule_enabled <= 1'b0;
      cfg.compare_operator <= OP_GT;
      cfg.rhs_from_input <= 1'b0;
      cfg.threshold_value <= '0;
      cfg.active_level <= 1'b1;
      cfg.rule_mode <= MODE_FOLLOW;
      cfg.hold_ms <= MS_PER_SECOND[HOLD_MS_W-1:0];
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

FILE: hdl/trot_eval.sv
// Per-item rule evaluation: compare, edge detect, deadline arm and expiry check.
// Depends on trot_pkg; purely combinational.
`timescale 1ns / 1ps

module trot_eval
  import trot_pkg::*;
(
  input  rule_cfg_t   cfg,
  input  sample_t     item,
  input  rule_state_t state,
  output rule_state_t state_next,
  output logic        emit,
  output drive_t      result
);

  logic signed [31:0] rhs;
  logic               cond;
  logic               rising;
  logic [31:0]        since_deadline;

  always_comb begin
    rhs = cfg.rhs_from_input ? item.second_value : cfg.threshold_value;
    case (cfg.compare_operator)
      OP_GT:   cond = item.measured_value > rhs;
      OP_GE:   cond = item.measured_value >= rhs;
      OP_LT:   cond = item.measured_value < rhs;
      OP_LE:   cond = item.measured_value <= rhs;
      OP_EQ:   cond = item.measured_value == rhs;
      OP_NE:   cond = item.measured_value != rhs;
      default: cond = 1'b0;
    endcase
    rising = cond && !state.previous_condition;
    since_deadline = item.now_ms - state.deadline_ms;

    state_next = state;
    emit = 1'b0;
    result.drive_level = cfg.active_level;
    result.drive_cause = CAUSE_FOLLOW;

    if (cfg.rule_enabled) begin
      state_next.previous_condition = cond;
      if (cfg.rule_mode == MODE_FOLLOW) begin
        emit = 1'b1;
        result.drive_level = cond ? cfg.active_level : !cfg.active_level;
      end else if (rising) begin
        emit = 1'b1;
        result.drive_cause = CAUSE_TRIGGER;
        state_next.hold_active = 1'b1;
        state_next.deadline_ms = item.now_ms + {1'b0, cfg.hold_ms};
      end else if (state.hold_active && !since_deadline[31]) begin
        emit = 1'b1;
        result.drive_level = !cfg.active_level;
        result.drive_cause = CAUSE_EXPIRE;
        state_next.hold_active = 1'b0;
      end
    end
  end

endmodule

FILE: hdl/threshold_rule_output_timer_top.sv
// Top level of the threshold rule output timer: sample register, rule state, result register.
// Depends on trot_pkg, trot_cfg, trot_eval and threshold_rule_output_timer_top_defines.svh.
`timescale 1ns / 1ps

// The block takes one sample item per clock cycle while it is not stalled. The sample is
// registered at the edge that accepts it and evaluated against the rule state in the
// following cycle; its result is loaded into an output register at the edge at which
// the sample advances, and is held there until it is taken. The rule state is updated
// at the same edge that loads the result, so consecutive items see each other's effect
// without a gap. A full output register stalls the sample register only when the waiting
// sample produces a result; samples that produce nothing pass through regardless.
// Configuration writes are taken in every cycle.

`include "threshold_rule_output_timer_top_defines.svh"

module threshold_rule_output_timer_top
  import trot_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample,
  output logic        drive_valid,
  input  logic        drive_ready,
  output drive_t      drive
);

  rule_cfg_t   cfg;
  rule_state_t state;
  rule_state_t state_next;
  sample_t     sample_q;
  logic        sample_q_valid;
  logic        emit;
  drive_t      result;
  logic        advance;

  assign cfg_ready = 1'b1;

  trot_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  trot_eval u_eval (
    .cfg        (cfg),
    .item       (sample_q),
    .state      (state),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  assign advance = sample_q_valid && (!emit || !drive_valid || drive_ready);
  assign sample_ready = !sample_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_q_valid <= 1'b0;
      drive_valid <= 1'b0;
      state <= '0;
    end else begin
      if (sample_ready) begin
        sample_q_valid <= sample_valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && emit) begin
        drive_valid <= 1'b1;
      end else if (drive_ready) begin
        drive_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      sample_q <= sample;
    end
    if (advance && emit) begin
      drive <= result;
    end
  end

  `TROT_ASSERT_ALWAYS(a_reset_clears_output,
    rst |=> !drive_valid && !sample_q_valid,
    "output or sample register valid after reset")
  `TROT_ASSERT(a_trigger_arms_hold,
    (advance && emit && result.drive_cause == CAUSE_TRIGGER) |=> state.hold_active,
    "trigger did not arm the hold")
  `TROT_ASSERT(a_trigger_deadline,
    (advance && emit && result.drive_cause == CAUSE_TRIGGER) |=>
      (state.deadline_ms - $past(sample_q.now_ms)) == {1'b0, $past(cfg.hold_ms)},
    "deadline not armed at now plus hold time")
  `TROT_ASSERT(a_expire_clears_hold,
    (advance && emit && result.drive_cause == CAUSE_EXPIRE) |=> !state.hold_active,
    "expiry did not clear the hold")

endmodule
